@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/tcsl_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsl_pkg
// Types, constants, arithmetic helpers and the micro-program of the
// characteristic slope limiter.
// ----------------------------------------------------------------------------
package tcsl_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int SCALE_BITS = 26;
    localparam int ADDR_BITS = 7;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int QPROD_BITS = PROD_BITS - FRAC_BITS;
    localparam int SQ_BITS = WORD_BITS + FRAC_BITS;
    localparam int SQRT_STEPS = SQ_BITS / 2;
    localparam int RCP_STEPS = 2 * FRAC_BITS + 1;
    localparam int CNT_BITS = 6;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0] t_addr;

    localparam t_word W_MAX = 32'sh7FFF_FFFF;
    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_ZERO = 32'sh0000_0000;
    // reciprocal of any divisor at or below this saturates
    localparam logic [WORD_BITS-1:0] RCP_SAT_LIMIT = 32'h0002_0000;

    // request kinds and slot limits
    localparam logic REQ_GEOM = 1'b0;
    localparam logic REQ_COMP = 1'b1;
    localparam logic [2:0] NODE_LAST = 3'd1;
    localparam logic [2:0] SLOT_LAST = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_LIMITED = 2'd0;
    localparam logic [1:0] STAT_CLIPPED = 2'd1;
    localparam logic [1:0] STAT_POLE = 2'd2;
    localparam logic [1:0] STAT_DEGEN = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  slot;
        logic [1:0]  pole_flags;
        t_word       h_xx;
        t_word       h_xz;
        t_word       h_yy;
        t_word       h_zz;
        t_word       left_mean;
        t_word       centre_mean;
        t_word       centre_slope;
        t_word       centre_cross;
        t_word       right_mean;
    } t_in;

    typedef struct packed {
        logic [2:0]  comp_index;
        t_word       new_theta_slope;
        t_word       new_cross_slope;
        logic [1:0]  cell_status;
        logic        last_flag;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP, OP_HALF, OP_ADD, OP_SUB, OP_NEG, OP_MUL,
        OP_MM2, OP_TPOS, OP_CLIP, OP_SQRT, OP_RCP
    } t_op;

    typedef struct packed {
        t_op   op;
        t_addr dst;
        t_addr a;
        t_addr b;
    } t_uop;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RD, S_EXE, S_ITER, S_WB, S_ORD, S_OWR
    } t_state;

    // scratch memory map
    localparam t_addr A_G = 7'd0;
    localparam t_addr A_C = 7'd8;
    localparam t_addr A_JS = 7'd38;
    localparam t_addr A_HRR = 7'd40;
    localparam t_addr A_HRP = 7'd41;
    localparam t_addr A_HTT = 7'd42;
    localparam t_addr A_HPP = 7'd43;
    localparam t_addr A_P1 = 7'd44;
    localparam t_addr A_P2 = 7'd45;
    localparam t_addr A_UND = 7'd46;
    localparam t_addr A_DTH = 7'd47;
    localparam t_addr A_SRR = 7'd48;
    localparam t_addr A_STT = 7'd49;
    localparam t_addr A_IRR = 7'd50;
    localparam t_addr A_ITT = 7'd51;
    localparam t_addr A_ID = 7'd52;
    localparam t_addr A_M2 = 7'd53;
    localparam t_addr A_M3 = 7'd54;
    localparam t_addr A_T = 7'd55;
    localparam t_addr A_MRP = 7'd56;
    localparam t_addr A_MPP = 7'd57;
    localparam t_addr A_X = 7'd58;
    localparam t_addr A_Y = 7'd59;
    localparam t_addr A_N = 7'd60;
    localparam t_addr A_DIF = 7'd61;
    localparam t_addr A_DL = 7'd64;
    localparam t_addr A_DR = 7'd70;
    localparam t_addr A_TB = 7'd80;
    localparam t_addr A_LIM = 7'd90;
    localparam t_addr A_S1 = 7'd106;
    localparam t_addr A_S2 = 7'd107;
    localparam t_addr A_S4 = 7'd108;
    localparam t_addr A_S5 = 7'd109;
    localparam t_addr A_R = 7'd122;

    // program layout
    localparam logic [7:0] PC_JUMP = 8'd21;
    localparam logic [7:0] PC_DEC = 8'd45;
    localparam logic [7:0] PC_MM = 8'd93;
    localparam logic [7:0] PC_BACK = 8'd117;
    localparam logic [7:0] LAST_PC = 8'd130;

    function automatic t_word f_add_sat(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? W_MIN : W_MAX;
        return t_word'(s[WORD_BITS-1:0]);
    endfunction

    function automatic t_word f_sub_sat(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? W_MIN : W_MAX;
        return t_word'(s[WORD_BITS-1:0]);
    endfunction

    // exact floor((a + b) / 2)
    function automatic t_word f_half(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        return t_word'(s[WORD_BITS:1]);
    endfunction

    function automatic t_word f_neg(t_word a);
        return (a == W_MIN) ? W_MAX : -a;
    endfunction

    // two-way minmod; chained twice it gives the three-way one
    function automatic t_word f_mm2(t_word a, t_word b);
        if (a > 0 && b > 0) return (a < b) ? a : b;
        if (a < 0 && b < 0) return (a > b) ? a : b;
        return W_ZERO;
    endfunction

    function automatic logic [WORD_BITS-1:0] f_mag(t_word a);
        return a[WORD_BITS-1] ? (~a + 32'd1) : a;
    endfunction

    // drop fraction bits of a magnitude product, apply sign, saturate
    function automatic t_word f_mul_sat(logic [PROD_BITS-1:0] p, logic neg);
        logic [QPROD_BITS-1:0] q;
        q = p[PROD_BITS-1:FRAC_BITS];
        if (neg) begin
            if (q >= 40'h00_8000_0000) return W_MIN;
            return -t_word'(q[WORD_BITS-1:0]);
        end
        if (q > 40'h00_7FFF_FFFF) return W_MAX;
        return t_word'(q[WORD_BITS-1:0]);
    endfunction

    function automatic t_addr f_comp(logic [2:0] k, logic [2:0] j);
        return A_C + t_addr'(k) * 7'd5 + t_addr'(j);
    endfunction

    function automatic t_uop f_uop(t_op op, t_addr d, t_addr a, t_addr b);
        t_uop u;
        u.op = op;
        u.dst = d;
        u.a = a;
        u.b = b;
        return u;
    endfunction

    // operand i of jump set: 0 left, 1 centre slope, 2 right
    function automatic t_addr f_dadr(logic [1:0] set, logic [2:0] i);
        unique case (set)
            2'd0:    return A_DL + t_addr'(i);
            2'd1:    return f_comp(i, 3'd2);
            default: return A_DR + t_addr'(i);
        endcase
    endfunction

    function automatic t_addr f_tadr(logic [1:0] set, logic [3:0] off);
        return A_TB + t_addr'({set, 4'b0000}) + t_addr'(off);
    endfunction

    // wave k of a set: waves 2 and 3 alias tBx and tDx
    function automatic t_addr f_wadr(logic [1:0] set, logic [2:0] k);
        logic [3:0] off;
        unique case (k)
            3'd0:    off = 4'd6;
            3'd1:    off = 4'd7;
            3'd2:    off = 4'd3;
            3'd3:    off = 4'd0;
            3'd4:    off = 4'd8;
            default: off = 4'd9;
        endcase
        return f_tadr(set, off);
    endfunction

    function automatic t_uop f_prog(logic [7:0] pc);
        logic [7:0] idx;
        logic [1:0] set;
        logic [2:0] k;
        t_uop u;
        u = f_uop(OP_NOP, A_X, A_X, A_X);
        if (pc < PC_JUMP) begin
            // metric average, determinant, roots, reciprocals, frame
            unique case (pc[4:0])
                5'd0:  u = f_uop(OP_HALF, A_HRR, A_G + 7'd0, A_G + 7'd4);
                5'd1:  u = f_uop(OP_HALF, A_HRP, A_G + 7'd1, A_G + 7'd5);
                5'd2:  u = f_uop(OP_HALF, A_HTT, A_G + 7'd2, A_G + 7'd6);
                5'd3:  u = f_uop(OP_HALF, A_HPP, A_G + 7'd3, A_G + 7'd7);
                5'd4:  u = f_uop(OP_MUL, A_P1, A_HRR, A_HPP);
                5'd5:  u = f_uop(OP_MUL, A_P2, A_HRP, A_HRP);
                5'd6:  u = f_uop(OP_SUB, A_UND, A_P1, A_P2);
                5'd7:  u = f_uop(OP_TPOS, A_X, A_UND, A_UND);
                5'd8:  u = f_uop(OP_TPOS, A_X, A_HRR, A_HRR);
                5'd9:  u = f_uop(OP_TPOS, A_X, A_HTT, A_HTT);
                5'd10: u = f_uop(OP_SQRT, A_DTH, A_UND, A_UND);
                5'd11: u = f_uop(OP_SQRT, A_SRR, A_HRR, A_HRR);
                5'd12: u = f_uop(OP_SQRT, A_STT, A_HTT, A_HTT);
                5'd13: u = f_uop(OP_RCP, A_IRR, A_SRR, A_SRR);
                5'd14: u = f_uop(OP_RCP, A_ITT, A_STT, A_STT);
                5'd15: u = f_uop(OP_RCP, A_ID, A_DTH, A_DTH);
                5'd16: u = f_uop(OP_MUL, A_M2, A_HRP, A_IRR);
                5'd17: u = f_uop(OP_MUL, A_M3, A_DTH, A_IRR);
                5'd18: u = f_uop(OP_MUL, A_T, A_M2, A_ID);
                5'd19: u = f_uop(OP_NEG, A_MRP, A_T, A_T);
                5'd20: u = f_uop(OP_MUL, A_MPP, A_SRR, A_ID);
                default: u = f_uop(OP_NOP, A_X, A_X, A_X);
            endcase
        end else if (pc < PC_DEC) begin
            // scaled left and right jumps, four steps per component
            idx = pc - PC_JUMP;
            k = idx[4:2];
            unique case (idx[1:0])
                2'd0: u = f_uop(OP_SUB, A_DIF, f_comp(k, 3'd1), f_comp(k, 3'd0));
                2'd1: u = f_uop(OP_MUL, A_DL + t_addr'(k), A_JS, A_DIF);
                2'd2: u = f_uop(OP_SUB, A_DIF, f_comp(k, 3'd4), f_comp(k, 3'd1));
                default: u = f_uop(OP_MUL, A_DR + t_addr'(k), A_JS, A_DIF);
            endcase
        end else if (pc < PC_MM) begin
            // characteristic decomposition, sixteen steps per set
            idx = pc - PC_DEC;
            set = idx[5:4];
            unique case (idx[3:0])
                4'd0:  u = f_uop(OP_MUL, f_tadr(set, 4'd0), A_STT, f_dadr(set, 3'd1));
                4'd1:  u = f_uop(OP_MUL, A_X, A_SRR, f_dadr(set, 3'd0));
                4'd2:  u = f_uop(OP_MUL, A_Y, A_M2, f_dadr(set, 3'd2));
                4'd3:  u = f_uop(OP_ADD, f_tadr(set, 4'd1), A_X, A_Y);
                4'd4:  u = f_uop(OP_MUL, f_tadr(set, 4'd2), A_M3, f_dadr(set, 3'd2));
                4'd5:  u = f_uop(OP_MUL, f_tadr(set, 4'd3), A_STT, f_dadr(set, 3'd4));
                4'd6:  u = f_uop(OP_MUL, A_X, A_SRR, f_dadr(set, 3'd3));
                4'd7:  u = f_uop(OP_MUL, A_Y, A_M2, f_dadr(set, 3'd5));
                4'd8:  u = f_uop(OP_ADD, f_tadr(set, 4'd4), A_X, A_Y);
                4'd9:  u = f_uop(OP_MUL, f_tadr(set, 4'd5), A_M3, f_dadr(set, 3'd5));
                4'd10: u = f_uop(OP_NEG, A_N, f_tadr(set, 4'd1), f_tadr(set, 4'd1));
                4'd11: u = f_uop(OP_HALF, f_tadr(set, 4'd6), A_N, f_tadr(set, 4'd5));
                4'd12: u = f_uop(OP_HALF, f_tadr(set, 4'd7), f_tadr(set, 4'd2),
                                 f_tadr(set, 4'd4));
                4'd13: u = f_uop(OP_HALF, f_tadr(set, 4'd8), f_tadr(set, 4'd1),
                                 f_tadr(set, 4'd5));
                4'd14: u = f_uop(OP_NEG, A_N, f_tadr(set, 4'd2), f_tadr(set, 4'd2));
                default: u = f_uop(OP_HALF, f_tadr(set, 4'd9), A_N, f_tadr(set, 4'd4));
            endcase
        end else if (pc < PC_BACK) begin
            // three-way minmod per wave and clip check
            idx = pc - PC_MM;
            k = idx[4:2];
            unique case (idx[1:0])
                2'd0: u = f_uop(OP_MM2, A_X, f_wadr(2'd0, k), f_wadr(2'd1, k));
                2'd1: u = f_uop(OP_MM2, A_LIM + t_addr'(k), A_X, f_wadr(2'd2, k));
                2'd2: u = f_uop(OP_CLIP, A_X, A_LIM + t_addr'(k), f_wadr(2'd1, k));
                default: u = f_uop(OP_NOP, A_X, A_X, A_X);
            endcase
        end else begin
            // back transform
            unique case (pc)
                8'd117: u = f_uop(OP_SUB, A_S1, A_LIM + 7'd4, A_LIM + 7'd0);
                8'd118: u = f_uop(OP_SUB, A_S2, A_LIM + 7'd1, A_LIM + 7'd5);
                8'd119: u = f_uop(OP_ADD, A_S4, A_LIM + 7'd1, A_LIM + 7'd5);
                8'd120: u = f_uop(OP_ADD, A_S5, A_LIM + 7'd0, A_LIM + 7'd4);
                8'd121: u = f_uop(OP_MUL, A_X, A_IRR, A_S1);
                8'd122: u = f_uop(OP_MUL, A_Y, A_MRP, A_S2);
                8'd123: u = f_uop(OP_ADD, A_R + 7'd0, A_X, A_Y);
                8'd124: u = f_uop(OP_MUL, A_R + 7'd1, A_ITT, A_LIM + 7'd3);
                8'd125: u = f_uop(OP_MUL, A_R + 7'd2, A_MPP, A_S2);
                8'd126: u = f_uop(OP_MUL, A_X, A_IRR, A_S4);
                8'd127: u = f_uop(OP_MUL, A_Y, A_MRP, A_S5);
                8'd128: u = f_uop(OP_ADD, A_R + 7'd3, A_X, A_Y);
                8'd129: u = f_uop(OP_MUL, A_R + 7'd4, A_ITT, A_LIM + 7'd2);
                8'd130: u = f_uop(OP_MUL, A_R + 7'd5, A_MPP, A_S5);
                default: u = f_uop(OP_NOP, A_X, A_X, A_X);
            endcase
        end
        return u;
    endfunction

endpackage

@@ rtl/tetrad_characteristic_slope_limiter.sv @@
// Geometry and component items 0..4: four or five words are stored, one word per cycle.
// Component item 5: a 131-step micro-program runs on one shared ALU (simple ops pass
// S_RD and S_EXE, multiplies add S_WB, roots and reciprocals add S_ITER and S_WB),
// then six results leave one at a time via S_ORD and S_OWR, the last as busy drops.
// Reset (synchronous, active low) clears control, pole state and jump_scale to 1.0.
// Results cannot be stalled: each is shown for one cycle under o_res_strobe.
// ----------------------------------------------------------------------------
// tetrad_characteristic_slope_limiter
// Characteristic minmod slope limiter on a face tetrad, built as a sequencer
// over a scratch memory and one shared arithmetic unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tetrad_characteristic_slope_limiter
    import tcsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SCALE_BITS-1:0] i_cfg_data,
    output logic                  o_res_strobe,
    output t_out                  o_result
);

    t_state r_state, n_state;
    t_in    r_item;
    logic [7:0] r_pc;
    logic [2:0] r_wcnt;
    logic [2:0] r_k;
    logic [SCALE_BITS-1:0] r_js;
    logic [1:0] r_pole;
    logic r_degen, r_clip;
    logic r_a_js;
    t_word r_rda, r_rdb;
    logic [PROD_BITS-1:0] r_prod;
    logic r_pneg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [WORD_BITS:0] r_rem;
    logic [WORD_BITS-1:0] r_quo;
    logic [SQ_BITS-1:0] r_sx;
    t_out r_out;
    logic r_out_valid;
    t_word r_mem [0:(1 << ADDR_BITS)-1];

    t_uop uop;
    t_word opa, alu_res, wb_res;
    logic accept, slot_ok, load_last, run_cell, op_last;
    logic mem_we;
    t_addr mem_wa, rd_addr_a, rd_addr_b;
    t_word mem_wd, load_word;
    logic [WORD_BITS:0] sq_rem, sq_trial, rc_rem, rc_div;

    assign uop = f_prog(r_pc);
    assign opa = r_a_js ? t_word'({{(WORD_BITS-SCALE_BITS){1'b0}}, r_js}) : r_rda;
    assign accept = start && !busy;
    assign slot_ok = (i_item.req_type == REQ_COMP) ? (i_item.slot <= SLOT_LAST)
                                                   : (i_item.slot <= NODE_LAST);
    assign load_last = (r_item.req_type == REQ_COMP) ? (r_wcnt == 3'd4) : (r_wcnt == 3'd3);
    assign run_cell = (r_item.req_type == REQ_COMP) && (r_item.slot == SLOT_LAST);
    assign op_last = (r_pc == LAST_PC);

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_strobe = r_out_valid;
    assign o_result = r_out;

    // combinational ALU for the simple ops
    always_comb begin
        unique case (uop.op)
            OP_HALF: alu_res = f_half(opa, r_rdb);
            OP_ADD:  alu_res = f_add_sat(opa, r_rdb);
            OP_SUB:  alu_res = f_sub_sat(opa, r_rdb);
            OP_NEG:  alu_res = f_neg(opa);
            OP_MM2:  alu_res = f_mm2(opa, r_rdb);
            default: alu_res = opa;
        endcase
    end

    // results of multiply, root and reciprocal ops
    always_comb begin
        unique case (uop.op)
            OP_MUL:  wb_res = f_mul_sat(r_prod, r_pneg);
            OP_RCP:  wb_res = ($unsigned(r_rda) <= RCP_SAT_LIMIT) ? W_MAX : t_word'(r_quo);
            default: wb_res = t_word'(r_quo);
        endcase
    end

    // one step of root and of reciprocal
    assign sq_rem = {r_rem[WORD_BITS-2:0], r_sx[SQ_BITS-1:SQ_BITS-2]};
    assign sq_trial = {r_quo[WORD_BITS-2:0], 2'b01};
    assign rc_rem = {r_rem[WORD_BITS-1:0], (r_cnt == CNT_BITS'(RCP_STEPS - 1))};
    assign rc_div = {1'b0, r_rda};

    // select the item word being stored
    always_comb begin
        unique case (r_wcnt)
            3'd0:    load_word = (r_item.req_type == REQ_COMP) ? r_item.left_mean : r_item.h_xx;
            3'd1:    load_word = (r_item.req_type == REQ_COMP) ? r_item.centre_mean
                                                               : r_item.h_xz;
            3'd2:    load_word = (r_item.req_type == REQ_COMP) ? r_item.centre_slope
                                                               : r_item.h_yy;
            3'd3:    load_word = (r_item.req_type == REQ_COMP) ? r_item.centre_cross
                                                               : r_item.h_zz;
            default: load_word = r_item.right_mean;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && slot_ok) n_state = S_LOAD;
            S_LOAD: begin
                if (load_last) n_state = run_cell ? S_RD : S_IDLE;
            end
            S_RD: n_state = S_EXE;
            S_EXE: begin
                if (uop.op == OP_MUL) n_state = S_WB;
                else if (uop.op == OP_SQRT || uop.op == OP_RCP) n_state = S_ITER;
                else n_state = op_last ? S_ORD : S_RD;
            end
            S_ITER: if (r_cnt == '0) n_state = S_WB;
            S_WB:   n_state = op_last ? S_ORD : S_RD;
            S_ORD:  n_state = S_OWR;
            S_OWR:  n_state = (r_k == SLOT_LAST) ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = uop.dst;
        mem_wd = alu_res;
        rd_addr_a = uop.a;
        rd_addr_b = uop.b;
        unique case (r_state)
            S_LOAD: begin
                mem_we = 1'b1;
                mem_wd = load_word;
                mem_wa = (r_item.req_type == REQ_COMP) ? f_comp(r_item.slot, r_wcnt)
                                                       : A_G + t_addr'({r_item.slot[0],
                                                                        r_wcnt[1:0]});
            end
            S_EXE: begin
                mem_we = (uop.op == OP_HALF) || (uop.op == OP_ADD) || (uop.op == OP_SUB)
                      || (uop.op == OP_NEG) || (uop.op == OP_MM2);
            end
            S_WB: begin
                mem_we = 1'b1;
                mem_wd = wb_res;
            end
            S_ORD: begin
                rd_addr_a = r_degen ? f_comp(r_k, 3'd2) : A_R + t_addr'(r_k);
                rd_addr_b = f_comp(r_k, 3'd3);
            end
            default: mem_we = 1'b0;
        endcase
    end

    // scratch memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (r_state == S_RD || r_state == S_ORD) begin
            r_rda <= r_mem[rd_addr_a];
            r_rdb <= r_mem[rd_addr_b];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_js <= SCALE_BITS'(1 << FRAC_BITS);
            r_pole <= '0;
            r_out_valid <= 1'b0;
            r_pc <= '0;
            r_wcnt <= '0;
            r_k <= '0;
            r_degen <= 1'b0;
            r_clip <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= (r_state == S_OWR);
            // take configuration transfer
            if (i_cfg_valid && o_cfg_ready) r_js <= i_cfg_data;
            // accept item, keep pole flags of geometry items
            if (accept && slot_ok) begin
                r_wcnt <= '0;
                if (i_item.req_type == REQ_GEOM) r_pole <= i_item.pole_flags;
            end
            if (r_state == S_LOAD) begin
                r_wcnt <= r_wcnt + 3'd1;
                r_pc <= '0;
                r_k <= '0;
                r_degen <= 1'b0;
                r_clip <= 1'b0;
            end
            // advance program counter after each op
            if ((r_state == S_EXE && n_state != S_WB && n_state != S_ITER)
                || r_state == S_WB) begin
                if (!op_last) r_pc <= r_pc + 8'd1;
            end
            // sticky geometry and clip flags
            if (r_state == S_EXE && uop.op == OP_TPOS && !(opa > 0)) r_degen <= 1'b1;
            if (r_state == S_EXE && uop.op == OP_CLIP && opa != r_rdb) r_clip <= 1'b1;
            if (r_state == S_OWR) r_k <= r_k + 3'd1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_item;
        if (r_state == S_RD) r_a_js <= (uop.a == A_JS);
        if (r_state == S_EXE) begin
            r_prod <= f_mag(opa) * f_mag(r_rdb);
            r_pneg <= opa[WORD_BITS-1] ^ r_rdb[WORD_BITS-1];
            r_rem <= '0;
            r_quo <= '0;
            r_sx <= {opa, {FRAC_BITS{1'b0}}};
            r_cnt <= (uop.op == OP_SQRT) ? CNT_BITS'(SQRT_STEPS - 1)
                                         : CNT_BITS'(RCP_STEPS - 1);
        end
        // iterate root or reciprocal one bit per cycle
        if (r_state == S_ITER) begin
            r_cnt <= r_cnt - 1'b1;
            if (uop.op == OP_SQRT) begin
                r_sx <= {r_sx[SQ_BITS-3:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    r_rem <= sq_rem - sq_trial;
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= sq_rem;
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                end
            end else begin
                if (rc_rem >= rc_div) begin
                    r_rem <= rc_rem - rc_div;
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= rc_rem;
                    r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                end
            end
        end
        // form result
        if (r_state == S_OWR) begin
            r_out.comp_index <= r_k;
            r_out.last_flag <= (r_k == SLOT_LAST);
            if (r_pole != 2'b00) begin
                r_out.new_theta_slope <= W_ZERO;
                r_out.new_cross_slope <= W_ZERO;
                r_out.cell_status <= STAT_POLE;
            end else if (r_degen) begin
                r_out.new_theta_slope <= r_rda;
                r_out.new_cross_slope <= r_rdb;
                r_out.cell_status <= STAT_DEGEN;
            end else begin
                r_out.new_theta_slope <= r_rda;
                r_out.new_cross_slope <= r_clip ? W_ZERO : r_rdb;
                r_out.cell_status <= r_clip ? STAT_CLIPPED : STAT_LIMITED;
            end
        end
    end

    `ASSERT_HOLDS(a_strobe_after_emit, i_clk, i_rst_n, o_res_strobe |-> $past(r_state == S_OWR), "result strobe without emit step")
    `ASSERT_HOLDS(a_last_frees_block, i_clk, i_rst_n, o_res_strobe && o_result.last_flag |-> !busy, "busy after last result")
    `ASSERT_HOLDS(a_busy_needs_start, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy rose without start")
    `ASSERT_NEVER(a_pc_in_program, i_clk, i_rst_n, r_pc > LAST_PC, "program counter past end")

endmodule
